@@ sv/cnde_pkg.sv @@
// Shared constants and controller/datapath handshake types for the card number digit extractor
package cnde_pkg;

   // source format selector codes (any other code is packed BCD)
   localparam logic [1:0] FMT_TRACK2 = 2'd0;
   localparam logic [1:0] FMT_TRACK1 = 2'd1;

   // sticky record error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TOO_MANY = 2'd1;
   localparam logic [1:0] ERR_BAD_NIB  = 2'd2;

   // result outcome codes
   localparam logic [2:0] OUT_OK       = 3'd0;
   localparam logic [2:0] OUT_NO_SEP   = 3'd3;
   localparam logic [2:0] OUT_TOO_FEW  = 3'd4;

   typedef struct packed {
      logic consume;      // take the accepted record byte
      logic load_status;  // load a status word into the output register
      logic load_digit;   // load the next stored digit into the output register
   } cmd_type;

   typedef struct packed {
      logic record_ok;    // record has no error, an end mark if track-2, and enough digits
      logic last_digit;   // drain pointer is at the final stored digit
   } stat_type;

endpackage

@@ sv/cnde_req_if.sv @@
// Record byte channel: valid/ready with one byte and its last-byte flag
interface cnde_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] record_byte;
   logic       final_byte;

   modport source (output valid, output record_byte, output final_byte, input ready);
   modport sink   (input valid, input record_byte, input final_byte, output ready);
endinterface

@@ sv/cnde_rsp_if.sv @@
// Result channel: valid/ready with one digit or status word
interface cnde_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] digit_value;
   logic [2:0] outcome;
   logic [4:0] total_digits;
   logic       run_end;

   modport source (output valid, output digit_value, output outcome, output total_digits,
                   output run_end, input ready);
   modport sink   (input valid, input digit_value, input outcome, input total_digits,
                   input run_end, output ready);
endinterface

@@ sv/card_number_digit_extractor_core.sv @@
// Top level of the card number digit extractor: controller, datapath and assertions
// Record bytes are taken one per cycle while collecting; each byte is decoded combinationally.
// After the final byte the controller loads one result word at a time: one status word,
// or one word per stored digit (up to MAX_DIGITS), paced by the output register's ready.
// The first result is loaded in the emit state, once the output register is free; no byte is taken while draining.
// Synchronous active-high reset clears the format to track-2, the record state and rsp valid.
module card_number_digit_extractor_core #(
   parameter int MAX_DIGITS = 19,
   parameter int MIN_DIGITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   cnde_req_if.sink          req_if,
   cnde_rsp_if.source        rsp_if,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data
);

   cnde_pkg::cmd_type  cmd;
   cnde_pkg::stat_type stat;

   cnde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_final (req_if.final_byte),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   cnde_dp #(
      .MAX_DIGITS (MAX_DIGITS),
      .MIN_DIGITS (MIN_DIGITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .record_byte  (req_if.record_byte),
      .cmd          (cmd),
      .stat         (stat),
      .digit_value  (rsp_if.digit_value),
      .outcome      (rsp_if.outcome),
      .total_digits (rsp_if.total_digits),
      .run_end      (rsp_if.run_end)
   );

   // output register is only reloaded once its word has gone
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_digit || cmd.load_status) |-> (!rsp_if.valid || rsp_if.ready))
      else $error("output word overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.final_byte) |=> !req_if.ready)
      else $error("byte taken straight after the final byte");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.outcome != cnde_pkg::OUT_OK) |-> rsp_if.run_end)
      else $error("status word without run end");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.outcome == cnde_pkg::OUT_OK) |-> (rsp_if.digit_value <= 4'd9))
      else $error("non-decimal digit emitted");

endmodule

@@ sv/cnde_ctrl.sv @@
// Controller: collects bytes, then emits a status word or drains the digit store
module cnde_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_final,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   input  cnde_pkg::stat_type stat,
   output cnde_pkg::cmd_type  cmd
);

   typedef enum logic {
      ST_COLLECT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_COLLECT);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_COLLECT: begin
            if (req_valid) begin
               cmd.consume = 1'b1;
               if (req_final) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (!stat.record_ok) begin
                  cmd.load_status = 1'b1;
                  state_in        = ST_COLLECT;
               end else begin
                  cmd.load_digit = 1'b1;
                  if (stat.last_digit) begin
                     state_in = ST_COLLECT;
                  end
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/cnde_dp.sv @@
// Datapath: byte decode, digit store, record state and the output word register
module cnde_dp #(
   parameter int MAX_DIGITS = 19,
   parameter int MIN_DIGITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_wr_data,
   input  logic [7:0]         record_byte,
   input  cnde_pkg::cmd_type  cmd,
   output cnde_pkg::stat_type stat,
   output logic [3:0]         digit_value,
   output logic [2:0]         outcome,
   output logic [4:0]         total_digits,
   output logic               run_end
);

   localparam int CW = $clog2(MAX_DIGITS + 1);
   localparam int AW = $clog2(MAX_DIGITS);

   typedef enum logic [1:0] {
      NK_DIGIT,
      NK_SKIP,
      NK_END,
      NK_BAD
   } nib_kind_type;

   logic [1:0]    fmt_ff;
   logic [CW-1:0] count_ff, count_in, count_mid;
   logic          ended_ff, ended_in;
   logic [1:0]    err_ff, err_in;
   logic [AW-1:0] ptr_ff;
   logic [3:0]    store [MAX_DIGITS];

   logic [3:0]    digit_ff;
   logic [2:0]    outcome_ff;
   logic [4:0]    total_ff;
   logic          run_end_ff;

   nib_kind_type  hi_kind, lo_kind;
   logic [3:0]    hi_val, lo_val;
   logic          wr0, wr1, stop;
   logic [2:0]    status;
   logic          clear;

   // track-2 nibble: D ends, F skipped
   function automatic nib_kind_type t2_kind(input logic [3:0] n);
      if (n <= 4'd9) return NK_DIGIT;
      if (n == 4'hD) return NK_END;
      if (n == 4'hF) return NK_SKIP;
      return NK_BAD;
   endfunction

   always_comb begin
      hi_val = record_byte[7:4];
      lo_val = record_byte[3:0];
      if (fmt_ff == cnde_pkg::FMT_TRACK2) begin
         hi_kind = t2_kind(record_byte[7:4]);
         lo_kind = t2_kind(record_byte[3:0]);
      end else if (fmt_ff == cnde_pkg::FMT_TRACK1) begin
         // whole ASCII byte goes through the high slot; low digit of '0'..'9' is the value
         hi_val  = record_byte[3:0];
         lo_kind = NK_SKIP;
         if (record_byte inside {[8'h30:8'h39]}) begin
            hi_kind = NK_DIGIT;
         end else if (record_byte == 8'h5E || record_byte == 8'h00) begin
            hi_kind = NK_END;
         end else begin
            hi_kind = NK_SKIP;
         end
      end else begin
         if (record_byte[7:4] <= 4'd9) hi_kind = NK_DIGIT;
         else if (record_byte[7:4] == 4'hF) hi_kind = NK_SKIP;
         else hi_kind = NK_BAD;
         if (record_byte[3:0] <= 4'd9) lo_kind = NK_DIGIT;
         else if (record_byte[3:0] == 4'hF) lo_kind = NK_END;
         else lo_kind = NK_BAD;
      end
   end

   // apply high then low slot; an end or error drops the rest of the byte
   always_comb begin
      wr0      = 1'b0;
      wr1      = 1'b0;
      stop     = ended_ff || (err_ff != cnde_pkg::ERR_NONE);
      ended_in = ended_ff;
      err_in   = err_ff;
      if (!stop) begin
         case (hi_kind)
            NK_DIGIT: begin
               if (count_ff < CW'(MAX_DIGITS)) begin
                  wr0 = 1'b1;
               end else begin
                  err_in = cnde_pkg::ERR_TOO_MANY;
                  stop   = 1'b1;
               end
            end
            NK_END: begin
               ended_in = 1'b1;
               stop     = 1'b1;
            end
            NK_BAD: begin
               err_in = cnde_pkg::ERR_BAD_NIB;
               stop   = 1'b1;
            end
            default: ;
         endcase
      end
      count_mid = count_ff + CW'(wr0);
      if (!stop) begin
         case (lo_kind)
            NK_DIGIT: begin
               if (count_mid < CW'(MAX_DIGITS)) begin
                  wr1 = 1'b1;
               end else begin
                  err_in = cnde_pkg::ERR_TOO_MANY;
               end
            end
            NK_END: begin
               ended_in = 1'b1;
            end
            NK_BAD: begin
               err_in = cnde_pkg::ERR_BAD_NIB;
            end
            default: ;
         endcase
      end
      count_in = count_mid + CW'(wr1);
   end

   always_comb begin
      if (err_ff != cnde_pkg::ERR_NONE) begin
         status = 3'(err_ff);
      end else if (fmt_ff == cnde_pkg::FMT_TRACK2 && !ended_ff) begin
         status = cnde_pkg::OUT_NO_SEP;
      end else if (count_ff < CW'(MIN_DIGITS)) begin
         status = cnde_pkg::OUT_TOO_FEW;
      end else begin
         status = cnde_pkg::OUT_OK;
      end
   end

   assign stat.record_ok  = (status == cnde_pkg::OUT_OK);
   assign stat.last_digit = ((CW'(ptr_ff) + CW'(1)) == count_ff);
   assign clear = cmd.load_status || (cmd.load_digit && stat.last_digit);

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= cnde_pkg::FMT_TRACK2;
         count_ff <= '0;
         ended_ff <= 1'b0;
         err_ff   <= cnde_pkg::ERR_NONE;
         ptr_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            fmt_ff <= csr_wr_data;
         end
         if (clear) begin
            count_ff <= '0;
            ended_ff <= 1'b0;
            err_ff   <= cnde_pkg::ERR_NONE;
            ptr_ff   <= '0;
         end else begin
            if (cmd.consume) begin
               count_ff <= count_in;
               ended_ff <= ended_in;
               err_ff   <= err_in;
            end
            if (cmd.load_digit) begin
               ptr_ff <= ptr_ff + AW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.consume && wr0) begin
         store[count_ff[AW-1:0]] <= hi_val;
      end
      if (cmd.consume && wr1) begin
         store[count_mid[AW-1:0]] <= lo_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_status) begin
         digit_ff   <= 4'd0;
         outcome_ff <= status;
         total_ff   <= 5'(count_ff);
         run_end_ff <= 1'b1;
      end else if (cmd.load_digit) begin
         digit_ff   <= store[ptr_ff];
         outcome_ff <= cnde_pkg::OUT_OK;
         total_ff   <= 5'(count_ff);
         run_end_ff <= stat.last_digit;
      end
   end

   assign digit_value  = digit_ff;
   assign outcome      = outcome_ff;
   assign total_digits = total_ff;
   assign run_end      = run_end_ff;

endmodule
